// ===== rtl/smw_pkg.sv =====
// ----------------------------------------------------------------------------
// smw_pkg
// Shared types and constants of the stick to mecanum wheel speed unit.
// ----------------------------------------------------------------------------
package smw_pkg;

    localparam int LIN_SCALE      = 15;
    localparam int LIN_LIMIT      = 8000;
    localparam int ROT_LIMIT      = 400;
    localparam int LIN_W          = 14;
    localparam int ROT_W          = 10;
    localparam int WHEEL_WIDE_W   = 16;
    localparam int WHEEL_NARROW_W = 15;
    localparam int MIX_W          = 18;

    localparam int EDGE_LOW_RESET  = 1950;
    localparam int EDGE_HIGH_RESET = 2150;

    // reciprocal of 5 at 2^20 and of 10 at 2^21, rounded up
    localparam logic [17:0] RECIP_FIVE     = 18'd209716;
    localparam int          RECIP_FIVE_SH  = 20;
    localparam logic [17:0] RECIP_TEN      = 18'd209716;
    localparam int          RECIP_TEN_SH   = 21;

    localparam logic [7:0] STOP_SWITCH_ON = 8'd1;

    localparam int CFG_INDEX_W = 3;
    localparam int NUM_EDGES   = 6;

    typedef enum logic [7:0] {
        MODE_LOCK_FWD  = 8'd3,
        MODE_LOCK_SIDE = 8'd4,
        MODE_STOP      = 8'd14
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROLL_LOW      = 3'd0,
        REG_ROLL_HIGH     = 3'd1,
        REG_THROTTLE_LOW  = 3'd2,
        REG_THROTTLE_HIGH = 3'd3,
        REG_YAW_LOW       = 3'd4,
        REG_YAW_HIGH      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [LIN_W-1:0] vx;
        logic signed [LIN_W-1:0] vy;
        logic signed [ROT_W-1:0] vz;
        logic                    stop;
    } speeds_t;

    typedef struct packed {
        logic                             stopped;
        logic signed [WHEEL_WIDE_W-1:0]   wheel_four;
        logic signed [WHEEL_NARROW_W-1:0] wheel_three;
        logic signed [WHEEL_NARROW_W-1:0] wheel_two;
        logic signed [WHEEL_WIDE_W-1:0]   wheel_one;
    } wheels_t;

endpackage

// ===== rtl/smw_deadzone.sv =====
// ----------------------------------------------------------------------------
// smw_deadzone
// Distance of one stick sample past the nearer deadzone edge.
// ----------------------------------------------------------------------------
module smw_deadzone #(
    parameter int STICK_BITS = 12
) (
    input  logic [STICK_BITS-1:0]        stick,
    input  logic [STICK_BITS-1:0]        low_edge,
    input  logic [STICK_BITS-1:0]        high_edge,
    output logic signed [STICK_BITS:0]   past
);
    always_comb
    begin
        if (stick > high_edge)
        begin
            past = $signed({1'b0, stick}) - $signed({1'b0, high_edge});
        end
        else if (stick < low_edge)
        begin
            past = $signed({1'b0, stick}) - $signed({1'b0, low_edge});
        end
        else
        begin
            past = '0;
        end
    end
endmodule

// ===== rtl/smw_speed.sv =====
// ----------------------------------------------------------------------------
// smw_speed
// Deadzone, clamping and mode lock of the three stick commands, scaling of roll
// and throttle, negation of yaw, and the stop flag.
module smw_speed #(
    parameter int STICK_BITS = 12
) (
    input  logic [STICK_BITS-1:0]                    roll_stick,
    input  logic [STICK_BITS-1:0]                    throttle_stick,
    input  logic [STICK_BITS-1:0]                    yaw_stick,
    input  logic [7:0]                               stop_switch,
    input  logic [7:0]                               mode_code,
    input  logic [smw_pkg::NUM_EDGES-1:0][STICK_BITS-1:0] edges,
    output smw_pkg::speeds_t                         speeds
);
    import smw_pkg::*;

    localparam int PW = (STICK_BITS + 5 > LIN_W + 1) ? STICK_BITS + 5 : LIN_W + 1;
    localparam int RW = (STICK_BITS + 2 > ROT_W + 1) ? STICK_BITS + 2 : ROT_W + 1;
    localparam logic signed [PW-1:0] LIN_MAX = PW'(LIN_LIMIT);
    localparam logic signed [RW-1:0] ROT_MAX = RW'(ROT_LIMIT);

    logic signed [STICK_BITS:0] roll_past;
    logic signed [STICK_BITS:0] thr_past;
    logic signed [STICK_BITS:0] yaw_past;
    logic signed [PW-1:0]       roll_ext;
    logic signed [PW-1:0]       thr_ext;
    logic signed [PW-1:0]       roll_scaled;
    logic signed [PW-1:0]       thr_scaled;
    logic signed [RW-1:0]       yaw_neg;
    logic signed [LIN_W-1:0]    vx_clamped;
    logic signed [LIN_W-1:0]    vy_clamped;
    logic signed [ROT_W-1:0]    vz_clamped;

    smw_deadzone #(.STICK_BITS(STICK_BITS)) u_roll_dz (
        .stick     (roll_stick),
        .low_edge  (edges[REG_ROLL_LOW]),
        .high_edge (edges[REG_ROLL_HIGH]),
        .past      (roll_past)
    );

    smw_deadzone #(.STICK_BITS(STICK_BITS)) u_thr_dz (
        .stick     (throttle_stick),
        .low_edge  (edges[REG_THROTTLE_LOW]),
        .high_edge (edges[REG_THROTTLE_HIGH]),
        .past      (thr_past)
    );

    smw_deadzone #(.STICK_BITS(STICK_BITS)) u_yaw_dz (
        .stick     (yaw_stick),
        .low_edge  (edges[REG_YAW_LOW]),
        .high_edge (edges[REG_YAW_HIGH]),
        .past      (yaw_past)
    );

    // times 15 as shift and subtract
    assign roll_ext    = PW'(roll_past);
    assign thr_ext     = PW'(thr_past);
    assign roll_scaled = (roll_ext <<< 4) - roll_ext;
    assign thr_scaled  = (thr_ext <<< 4) - thr_ext;
    assign yaw_neg     = -RW'(yaw_past);

    always_comb
    begin
        if (roll_scaled > LIN_MAX)
        begin
            vx_clamped = LIN_W'(LIN_MAX);
        end
        else if (roll_scaled < -LIN_MAX)
        begin
            vx_clamped = LIN_W'(-LIN_MAX);
        end
        else
        begin
            vx_clamped = LIN_W'(roll_scaled);
        end

        if (thr_scaled > LIN_MAX)
        begin
            vy_clamped = LIN_W'(LIN_MAX);
        end
        else if (thr_scaled < -LIN_MAX)
        begin
            vy_clamped = LIN_W'(-LIN_MAX);
        end
        else
        begin
            vy_clamped = LIN_W'(thr_scaled);
        end

        if (yaw_neg > ROT_MAX)
        begin
            vz_clamped = ROT_W'(ROT_MAX);
        end
        else if (yaw_neg < -ROT_MAX)
        begin
            vz_clamped = ROT_W'(-ROT_MAX);
        end
        else
        begin
            vz_clamped = ROT_W'(yaw_neg);
        end

        speeds.vx   = vx_clamped;
        speeds.vy   = vy_clamped;
        speeds.vz   = vz_clamped;
        speeds.stop = (stop_switch == STOP_SWITCH_ON) || (mode_code == MODE_STOP);
        if (mode_code == MODE_LOCK_FWD)
        begin
            speeds.vy = '0;
        end
        else if (mode_code == MODE_LOCK_SIDE)
        begin
            speeds.vx = '0;
        end
    end
endmodule

// ===== rtl/smw_mixer.sv =====
// ----------------------------------------------------------------------------
// smw_mixer
// Mecanum mix of the three body speeds into four wheel speeds; a stop zeroes
// all four and sets the stopped flag.
module smw_mixer (
    input  smw_pkg::speeds_t speeds,
    output smw_pkg::wheels_t wheels
);
    import smw_pkg::*;

    logic signed [MIX_W-1:0] vx_ext;
    logic signed [MIX_W-1:0] vy_ext;
    logic signed [MIX_W-1:0] vz_ext;
    logic signed [MIX_W-1:0] sum_one;
    logic signed [MIX_W-1:0] sum_two;
    logic signed [MIX_W-1:0] sum_three;
    logic signed [MIX_W-1:0] sum_four;
    logic [MIX_W-1:0]        mag_two;
    logic [MIX_W-1:0]        mag_three;
    logic [16:0]             num_two;
    logic [16:0]             num_three;
    logic [34:0]             prod_two;
    logic [34:0]             prod_three;
    logic [WHEEL_NARROW_W-1:0] quo_two;
    logic [WHEEL_NARROW_W-1:0] quo_three;

    assign vx_ext = MIX_W'(speeds.vx);
    assign vy_ext = MIX_W'(speeds.vy);
    assign vz_ext = MIX_W'(speeds.vz);

    assign sum_one   = vz_ext - vx_ext + vy_ext;
    assign sum_two   = vz_ext - vx_ext - vy_ext;
    assign sum_three = vz_ext + vx_ext - vy_ext;
    assign sum_four  = vz_ext + vx_ext + vy_ext;

    // truncation toward zero on the magnitude
    assign mag_two   = sum_two[MIX_W-1]   ? MIX_W'(-sum_two)   : MIX_W'(sum_two);
    assign mag_three = sum_three[MIX_W-1] ? MIX_W'(-sum_three) : MIX_W'(sum_three);

    assign num_two   = {mag_two[14:0], 2'b00};
    assign num_three = 17'({mag_three, 3'b000} - {3'b000, mag_three});

    assign prod_two   = 35'(num_two) * 35'(RECIP_FIVE);
    assign prod_three = 35'(num_three) * 35'(RECIP_TEN);

    assign quo_two   = WHEEL_NARROW_W'(prod_two >> RECIP_FIVE_SH);
    assign quo_three = WHEEL_NARROW_W'(prod_three >> RECIP_TEN_SH);

    always_comb
    begin
        if (speeds.stop)
        begin
            wheels = '0;
            wheels.stopped = 1'b1;
        end
        else
        begin
            wheels.stopped     = 1'b0;
            wheels.wheel_one   = WHEEL_WIDE_W'(sum_one);
            wheels.wheel_four  = WHEEL_WIDE_W'(sum_four);
            wheels.wheel_two   = sum_two[MIX_W-1]   ? WHEEL_NARROW_W'(-quo_two)   : quo_two;
            wheels.wheel_three = sum_three[MIX_W-1] ? WHEEL_NARROW_W'(-quo_three) : quo_three;
        end
    end
endmodule

// ===== rtl/stick_to_mecanum_wheel_speed_unit.sv =====
// ----------------------------------------------------------------------------
// stick_to_mecanum_wheel_speed_unit
// Remote-control stick sample to four mecanum wheel speeds.
// ----------------------------------------------------------------------------
// One stick sample enters as a beat on the s_axis channel; one beat with the
// four wheel speeds and the stop flag leaves on the m_axis channel.
// The user must write the six deadzone edges through cfg_wr_en / cfg_index /
// cfg_data only while no beat is in flight; the block does not enforce this.
// Indexes above 5 are ignored. Two register stages: the first holds the
// clamped body speeds, the second the wheel speeds.
// One beat is taken every cycle unless both stages hold a beat and m_axis_tready
// is low; the reciprocal multipliers of the second stage set the clock period.
// When m_axis_tready is low the result register holds and the first stage
// keeps filling; s_axis_tready drops once both stages hold a beat.
// Reset empties both stages and loads the default edges 1950 and 2150.
// ----------------------------------------------------------------------------
module stick_to_mecanum_wheel_speed_unit #(
    parameter int STICK_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // roll_stick, throttle_stick, yaw_stick, stop_switch, mode_code
    input  logic [((3*STICK_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // wheel_one, wheel_two, wheel_three, wheel_four, stopped
    output logic [63:0]                  m_axis_tdata,
    input  logic                         cfg_wr_en,
    input  logic [smw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [STICK_BITS-1:0]        cfg_data
);
    import smw_pkg::*;

    localparam int IN_W = ((3*STICK_BITS+16+7)/8)*8;
    localparam int SB   = STICK_BITS;

    logic [NUM_EDGES-1:0][SB-1:0] edge_reg;
    speeds_t                      speeds_next;
    speeds_t                      speeds_reg;
    logic                         s1_valid_reg;
    wheels_t                      wheels_next;
    wheels_t                      wheels_reg;
    logic                         out_valid_reg;
    logic                         out_advance;
    logic                         s1_advance;
    logic [IN_W-1:0]              in_data;

    assign in_data     = s_axis_tdata;
    assign out_advance = !out_valid_reg || m_axis_tready;
    assign s1_advance  = !s1_valid_reg || out_advance;

    assign s_axis_tready = s1_advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, wheels_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg[REG_ROLL_LOW]      <= SB'(EDGE_LOW_RESET);
            edge_reg[REG_ROLL_HIGH]     <= SB'(EDGE_HIGH_RESET);
            edge_reg[REG_THROTTLE_LOW]  <= SB'(EDGE_LOW_RESET);
            edge_reg[REG_THROTTLE_HIGH] <= SB'(EDGE_HIGH_RESET);
            edge_reg[REG_YAW_LOW]       <= SB'(EDGE_LOW_RESET);
            edge_reg[REG_YAW_HIGH]      <= SB'(EDGE_HIGH_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROLL_LOW:      edge_reg[REG_ROLL_LOW]      <= cfg_data;
                REG_ROLL_HIGH:     edge_reg[REG_ROLL_HIGH]     <= cfg_data;
                REG_THROTTLE_LOW:  edge_reg[REG_THROTTLE_LOW]  <= cfg_data;
                REG_THROTTLE_HIGH: edge_reg[REG_THROTTLE_HIGH] <= cfg_data;
                REG_YAW_LOW:       edge_reg[REG_YAW_LOW]       <= cfg_data;
                REG_YAW_HIGH:      edge_reg[REG_YAW_HIGH]      <= cfg_data;
                default:           ;
            endcase
        end
    end

    smw_speed #(.STICK_BITS(SB)) u_speed (
        .roll_stick     (in_data[SB-1:0]),
        .throttle_stick (in_data[2*SB-1:SB]),
        .yaw_stick      (in_data[3*SB-1:2*SB]),
        .stop_switch    (in_data[3*SB+7:3*SB]),
        .mode_code      (in_data[3*SB+15:3*SB+8]),
        .edges          (edge_reg),
        .speeds         (speeds_next)
    );

    smw_mixer u_mixer (
        .speeds (speeds_reg),
        .wheels (wheels_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (s1_advance && s_axis_tvalid)
        begin
            speeds_reg <= speeds_next;
        end
        if (out_advance && s1_valid_reg)
        begin
            wheels_reg <= wheels_next;
        end
    end
endmodule
